// ----- rtl/core/skt_pkg.sv -----
// ----------------------------------------------------------------------------
// skt_pkg
// Shared types and constants for the sorted key permission table.
// ----------------------------------------------------------------------------
package skt_pkg;

    // request type codes
    localparam logic REQ_GET = 1'b0;
    localparam logic REQ_SET = 1'b1;

    // result status codes
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    // cells between two registers of the lookup chain
    localparam int SEG_CELLS = 16;

    // request payload
    typedef struct packed {
        logic               req_type;
        logic signed [15:0] section_id;
        logic [15:0]        priv_value;
        logic               favor_flag;
    } skt_req_t;

    // response payload
    typedef struct packed {
        logic [15:0] priv_out;
        logic        favor_out;
        logic        status;
    } skt_rsp_t;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COMPARE,
        ST_SWEEP,
        ST_APPLY
    } skt_state_t;

    // sequencer strobes to the datapath
    typedef struct packed {
        logic req_ready;
        logic cmp_en;
        logic apply_en;
    } skt_ctrl_t;

    // per-cell operation strobes
    typedef struct packed {
        logic cmp_en;
        logic upd_en;
        logic ins_en;
    } skt_cell_op_t;

endpackage

// ----- rtl/core/sorted_key_priv_table_unit.sv -----
// ----------------------------------------------------------------------------
// sorted_key_priv_table_unit
// Permission table kept sorted by signed key in a row of cells.
// ----------------------------------------------------------------------------
// Requests come in on req_valid/req_stall/req_data and each gives exactly one
// response on rsp_valid/rsp_stall/rsp_data. A get returns the stored mask and
// favorite bit, or on a miss the global mask (key >= 0) or none_priv (key < 0).
// A set with key 0 writes the global mask; any other set updates the entry in
// place or inserts it in key order, shifting the higher cells up together.
// An insert into a full table is dropped and reported with status 1.
// A request passes from acceptance through a compare step in all cells, a sweep
// while the lookup result travels the registered chain of NSEG cell groups,
// NSEG = ceil(MAX_ENTRIES / 16), and an apply step. One request is in work at
// a time; the next one is taken in the idle state that follows the apply step.
// The response register lets the next request be taken while a response waits.
// If rsp_stall holds a response, the following request waits in its apply
// step. Reset clears the entry count, the global mask and none_priv; cell
// contents are not cleared. none_priv is written through cfg_wr_en/cfg_wr_data.
// ----------------------------------------------------------------------------
module sorted_key_priv_table_unit
    import skt_pkg::*;
#(
    parameter int MAX_ENTRIES = 256,
    parameter int KEY_BITS    = 16,
    parameter int PRIV_BITS   = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  skt_req_t    req_data,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output skt_rsp_t    rsp_data,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data
);

    localparam int NSEG  = (MAX_ENTRIES + SEG_CELLS - 1) / SEG_CELLS;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    skt_ctrl_t                  ctrl;
    skt_cell_op_t               cell_op;
    logic                       out_free;
    logic                       req_fire;

    logic                       type_reg;
    logic signed [KEY_BITS-1:0] key_reg;
    logic [PRIV_BITS-1:0]       priv_reg;
    logic                       favor_reg;
    logic signed [KEY_BITS-1:0] in_key;
    logic [PRIV_BITS-1:0]       in_priv;

    logic [CNT_W-1:0]           count_reg;
    logic [PRIV_BITS-1:0]       global_priv_reg;
    logic [15:0]                none_priv_reg;
    logic                       rsp_valid_reg;
    skt_rsp_t                   rsp_data_reg;

    logic                       cell_lt    [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0]     cell_eq;
    logic signed [KEY_BITS-1:0] cell_key   [MAX_ENTRIES];
    logic [PRIV_BITS-1:0]       cell_priv  [MAX_ENTRIES];
    logic                       cell_favor [MAX_ENTRIES];
    logic                       acc_hit    [MAX_ENTRIES];
    logic [PRIV_BITS-1:0]       acc_priv   [MAX_ENTRIES];
    logic                       acc_favor  [MAX_ENTRIES];
    logic                       seg_hit_reg   [NSEG];
    logic [PRIV_BITS-1:0]       seg_priv_reg  [NSEG];
    logic                       seg_favor_reg [NSEG];

    logic                       is_set;
    logic                       key_zero;
    logic                       hit;
    logic                       full;
    logic [15:0]                hit_priv16;
    logic [15:0]                global_priv16;
    skt_rsp_t                   rsp_next;

    // sequencer
    skt_ctrl #(
        .NSEG (NSEG)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .out_free  (out_free),
        .ctrl      (ctrl)
    );

    assign req_stall = !ctrl.req_ready;
    assign req_fire  = req_valid && ctrl.req_ready;
    assign out_free  = !rsp_valid_reg || !rsp_stall;

    // key and mask widths from the request fields
    generate
        if (KEY_BITS <= 16)
        begin : g_key_narrow
            assign in_key = req_data.section_id[KEY_BITS-1:0];
        end
        else
        begin : g_key_wide
            assign in_key = {{(KEY_BITS-16){req_data.section_id[15]}}, req_data.section_id};
        end
        if (PRIV_BITS <= 16)
        begin : g_priv_narrow
            assign in_priv       = req_data.priv_value[PRIV_BITS-1:0];
            assign hit_priv16    = {{(16-PRIV_BITS){1'b0}}, seg_priv_reg[NSEG-1]};
            assign global_priv16 = {{(16-PRIV_BITS){1'b0}}, global_priv_reg};
        end
        else
        begin : g_priv_wide
            assign in_priv       = {{(PRIV_BITS-16){1'b0}}, req_data.priv_value};
            assign hit_priv16    = seg_priv_reg[NSEG-1][15:0];
            assign global_priv16 = global_priv_reg[15:0];
        end
    endgenerate

    // request register
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            type_reg  <= req_data.req_type;
            key_reg   <= in_key;
            priv_reg  <= in_priv;
            favor_reg <= req_data.favor_flag;
        end
    end

    // decisions for the apply step
    assign is_set   = (type_reg == REQ_SET);
    assign key_zero = (key_reg == '0);
    assign hit      = seg_hit_reg[NSEG-1];
    assign full     = (count_reg == CNT_W'(MAX_ENTRIES));

    always_comb
    begin
        cell_op        = '0;
        cell_op.cmp_en = ctrl.cmp_en;
        cell_op.upd_en = ctrl.apply_en && is_set && !key_zero && hit;
        cell_op.ins_en = ctrl.apply_en && is_set && !key_zero && !hit && !full;
    end

    // row of cells
    genvar i;
    generate
        for (i = 0; i < MAX_ENTRIES; i++)
        begin : g_cell
            logic                       prev_lt;
            logic signed [KEY_BITS-1:0] prev_key;
            logic [PRIV_BITS-1:0]       prev_priv;
            logic                       prev_favor;
            logic                       in_hit;
            logic [PRIV_BITS-1:0]       in_pv;
            logic                       in_fv;

            if (i == 0)
            begin : g_first
                assign prev_lt    = 1'b1;
                assign prev_key   = key_reg;
                assign prev_priv  = priv_reg;
                assign prev_favor = favor_reg;
                assign in_hit     = 1'b0;
                assign in_pv      = '0;
                assign in_fv      = 1'b0;
            end
            else
            begin : g_next
                assign prev_lt    = cell_lt[i-1];
                assign prev_key   = cell_key[i-1];
                assign prev_priv  = cell_priv[i-1];
                assign prev_favor = cell_favor[i-1];
                if ((i % SEG_CELLS) == 0)
                begin : g_seg_in
                    assign in_hit = seg_hit_reg[i/SEG_CELLS - 1];
                    assign in_pv  = seg_priv_reg[i/SEG_CELLS - 1];
                    assign in_fv  = seg_favor_reg[i/SEG_CELLS - 1];
                end
                else
                begin : g_chain_in
                    assign in_hit = acc_hit[i-1];
                    assign in_pv  = acc_priv[i-1];
                    assign in_fv  = acc_favor[i-1];
                end
            end

            skt_cell #(
                .KEY_BITS  (KEY_BITS),
                .PRIV_BITS (PRIV_BITS)
            ) u_cell (
                .clk           (clk),
                .rst_n         (rst_n),
                .op            (cell_op),
                .slot_valid    (count_reg > CNT_W'(i)),
                .new_key       (key_reg),
                .new_priv      (priv_reg),
                .new_favor     (favor_reg),
                .prev_lt       (prev_lt),
                .prev_key      (prev_key),
                .prev_priv     (prev_priv),
                .prev_favor    (prev_favor),
                .acc_hit_in    (in_hit),
                .acc_priv_in   (in_pv),
                .acc_favor_in  (in_fv),
                .lt            (cell_lt[i]),
                .eq            (cell_eq[i]),
                .key           (cell_key[i]),
                .priv          (cell_priv[i]),
                .favor         (cell_favor[i]),
                .acc_hit_out   (acc_hit[i]),
                .acc_priv_out  (acc_priv[i]),
                .acc_favor_out (acc_favor[i])
            );
        end
    endgenerate

    // group registers of the lookup chain
    genvar s;
    generate
        for (s = 0; s < NSEG; s++)
        begin : g_seg
            localparam int LAST = ((s + 1) * SEG_CELLS < MAX_ENTRIES) ?
                                  (s + 1) * SEG_CELLS - 1 : MAX_ENTRIES - 1;
            always_ff @(posedge clk)
            begin
                seg_hit_reg[s]   <= acc_hit[LAST];
                seg_priv_reg[s]  <= acc_priv[LAST];
                seg_favor_reg[s] <= acc_favor[LAST];
            end
        end
    endgenerate

    // entry count, global mask and none mask
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg       <= '0;
            global_priv_reg <= '0;
            none_priv_reg   <= '0;
        end
        else
        begin
            if (cell_op.ins_en)
            begin
                count_reg <= count_reg + 1'b1;
            end
            if (ctrl.apply_en && is_set && key_zero)
            begin
                global_priv_reg <= priv_reg;
            end
            if (cfg_wr_en)
            begin
                none_priv_reg <= cfg_wr_data;
            end
        end
    end

    // response contents
    always_comb
    begin
        rsp_next = '0;
        if (!is_set)
        begin
            if (hit)
            begin
                rsp_next.priv_out  = hit_priv16;
                rsp_next.favor_out = seg_favor_reg[NSEG-1];
            end
            else
            begin
                rsp_next.priv_out = key_reg[KEY_BITS-1] ? none_priv_reg : global_priv16;
            end
            rsp_next.status = STATUS_OK;
        end
        else
        begin
            rsp_next.status = (!key_zero && !hit && full) ? STATUS_FULL : STATUS_OK;
        end
    end

    // response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (ctrl.apply_en)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.apply_en)
        begin
            rsp_data_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    // sorted distinct keys give at most one matching cell
    assert property (@(posedge clk) disable iff (!rst_n) $onehot0(cell_eq))
        else $error("more than one cell matches the request key");

    // the entry count never passes the capacity
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_ENTRIES))
        else $error("entry count beyond capacity");

    // the count only grows, one entry per apply step
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != $past(count_reg) |-> count_reg == $past(count_reg) + 1'b1)
        else $error("entry count moved by other than one");

    // a dropped insert carries no mask or favorite bit
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.status == STATUS_FULL |->
            rsp_data.priv_out == '0 && !rsp_data.favor_out)
        else $error("full status with nonzero payload");

endmodule

// ----- rtl/core/skt_cell.sv -----
// ----------------------------------------------------------------------------
// skt_cell
// One slot of the sorted table: holds an entry, compares it with the request
// key, shifts from its lower neighbor on insert, passes the lookup result on.
// ----------------------------------------------------------------------------
module skt_cell
    import skt_pkg::*;
#(
    parameter int KEY_BITS  = 16,
    parameter int PRIV_BITS = 16
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  skt_cell_op_t               op,
    input  logic                       slot_valid,
    input  logic signed [KEY_BITS-1:0] new_key,
    input  logic [PRIV_BITS-1:0]       new_priv,
    input  logic                       new_favor,
    input  logic                       prev_lt,
    input  logic signed [KEY_BITS-1:0] prev_key,
    input  logic [PRIV_BITS-1:0]       prev_priv,
    input  logic                       prev_favor,
    input  logic                       acc_hit_in,
    input  logic [PRIV_BITS-1:0]       acc_priv_in,
    input  logic                       acc_favor_in,
    output logic                       lt,
    output logic                       eq,
    output logic signed [KEY_BITS-1:0] key,
    output logic [PRIV_BITS-1:0]       priv,
    output logic                       favor,
    output logic                       acc_hit_out,
    output logic [PRIV_BITS-1:0]       acc_priv_out,
    output logic                       acc_favor_out
);

    logic                       lt_reg;
    logic                       eq_reg;
    logic signed [KEY_BITS-1:0] key_reg;
    logic [PRIV_BITS-1:0]       priv_reg;
    logic                       favor_reg;
    logic                       take_new;
    logic                       take_prev;

    // compare flags against the broadcast key
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lt_reg <= 1'b0;
            eq_reg <= 1'b0;
        end
        else if (op.cmp_en)
        begin
            lt_reg <= slot_valid && (key_reg < new_key);
            eq_reg <= slot_valid && (key_reg == new_key);
        end
    end

    // insert position: first slot not below the key
    assign take_new  = prev_lt && !lt_reg;
    assign take_prev = !prev_lt;

    // entry storage
    always_ff @(posedge clk)
    begin
        if (op.ins_en)
        begin
            if (take_new)
            begin
                key_reg   <= new_key;
                priv_reg  <= new_priv;
                favor_reg <= new_favor;
            end
            else if (take_prev)
            begin
                key_reg   <= prev_key;
                priv_reg  <= prev_priv;
                favor_reg <= prev_favor;
            end
        end
        else if (op.upd_en && eq_reg)
        begin
            priv_reg  <= new_priv;
            favor_reg <= new_favor;
        end
    end

    // lookup result passed along the chain
    assign acc_hit_out   = acc_hit_in | eq_reg;
    assign acc_priv_out  = acc_priv_in | (eq_reg ? priv_reg : '0);
    assign acc_favor_out = acc_favor_in | (eq_reg & favor_reg);

    assign lt    = lt_reg;
    assign eq    = eq_reg;
    assign key   = key_reg;
    assign priv  = priv_reg;
    assign favor = favor_reg;

endmodule

// ----- rtl/core/skt_ctrl.sv -----
// ----------------------------------------------------------------------------
// skt_ctrl
// Request sequencer: accept, compare, sweep the lookup chain, apply.
// ----------------------------------------------------------------------------
module skt_ctrl
    import skt_pkg::*;
#(
    parameter int NSEG = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    input  logic      out_free,
    output skt_ctrl_t ctrl
);

    localparam int SWP_W = (NSEG > 1) ? $clog2(NSEG) : 1;

    skt_state_t       state_reg;
    skt_state_t       state_next;
    logic [SWP_W-1:0] sweep_cnt_reg;
    logic [SWP_W-1:0] sweep_cnt_next;
    logic             sweep_last;

    assign sweep_last = (sweep_cnt_reg == SWP_W'(NSEG - 1));

    // state and sweep counter registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sweep_cnt_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            sweep_cnt_reg <= sweep_cnt_next;
        end
    end

    // next state
    always_comb
    begin
        state_next     = state_reg;
        sweep_cnt_next = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_COMPARE;
                end
            end
            ST_COMPARE:
            begin
                state_next = ST_SWEEP;
            end
            ST_SWEEP:
            begin
                if (sweep_last)
                begin
                    state_next = ST_APPLY;
                end
                else
                begin
                    sweep_cnt_next = sweep_cnt_reg + 1'b1;
                end
            end
            ST_APPLY:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        ctrl = '0;
        unique case (state_reg)
            ST_IDLE:    ctrl.req_ready = 1'b1;
            ST_COMPARE: ctrl.cmp_en    = 1'b1;
            ST_SWEEP:   ctrl.cmp_en    = 1'b0;
            ST_APPLY:   ctrl.apply_en  = out_free;
            default:    ctrl           = '0;
        endcase
    end

endmodule

// ----- tb/tb_sorted_key_priv_table_unit.sv -----
// ----------------------------------------------------------------------------
// tb_sorted_key_priv_table_unit
// Self-checking bench for the sorted key permission table.
// ----------------------------------------------------------------------------
// Gets and sets go in over the request channel while a local copy of the table
// (sorted keys, masks, favorite bits, entry count, global mask, none_priv)
// works out each response. Responses are checked field by field in order.
// Directed tests cover the empty table, key extremes, key 0, in-place updates
// and none_priv settings. Random tests then mix gets and sets, fill the table
// to capacity and keep going on a full table. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_sorted_key_priv_table_unit
    import skt_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH = 256;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        req_valid   = 1'b0;
    logic        req_stall;
    skt_req_t    req_data    = '0;
    logic        rsp_valid;
    logic        rsp_stall   = 1'b0;
    skt_rsp_t    rsp_data;
    logic        cfg_wr_en   = 1'b0;
    logic [15:0] cfg_wr_data = '0;

    // local copy of the table
    logic signed [15:0] tbl_key   [TABLE_DEPTH];
    logic [15:0]        tbl_priv  [TABLE_DEPTH];
    logic               tbl_favor [TABLE_DEPTH];
    int                 tbl_count   = 0;
    logic [15:0]        global_mask = '0;
    logic [15:0]        miss_mask   = '0;

    skt_rsp_t pending_rsp[$];
    int       err_count  = 0;
    bit       quiet_run  = 1'b0;

    sorted_key_priv_table_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req_data    (req_data),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp_data    (rsp_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // first slot whose key is not below the given key
    function automatic int find_slot(logic signed [15:0] key);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = tbl_count;
        while (lo < hi)
        begin
            mid = lo + (hi - lo) / 2;
            if (tbl_key[mid] < key)
                lo = mid + 1;
            else
                hi = mid;
        end
        return lo;
    endfunction

    function automatic bit key_present(logic signed [15:0] key);
        int pos;
        pos = find_slot(key);
        return (pos < tbl_count) && (tbl_key[pos] == key);
    endfunction

    // apply one request to the local table and return its response
    function automatic skt_rsp_t table_access(skt_req_t rq);
        skt_rsp_t           rs;
        logic signed [15:0] key;
        int                 pos;
        bit                 hit;
        rs        = '0;
        rs.status = STATUS_OK;
        key       = rq.section_id;
        pos       = find_slot(key);
        hit       = (pos < tbl_count) && (tbl_key[pos] == key);
        if (rq.req_type == REQ_GET)
        begin
            if (hit)
            begin
                rs.priv_out  = tbl_priv[pos];
                rs.favor_out = tbl_favor[pos];
            end
            else
                rs.priv_out = (key < 0) ? miss_mask : global_mask;
        end
        else if (key == 0)
            global_mask = rq.priv_value;
        else if (hit)
        begin
            tbl_priv[pos]  = rq.priv_value;
            tbl_favor[pos] = rq.favor_flag;
        end
        else if (tbl_count >= TABLE_DEPTH)
            rs.status = STATUS_FULL;
        else
        begin
            // shift higher entries up by one
            for (int i = tbl_count; i > pos; i--)
            begin
                tbl_key[i]   = tbl_key[i-1];
                tbl_priv[i]  = tbl_priv[i-1];
                tbl_favor[i] = tbl_favor[i-1];
            end
            tbl_key[pos]   = key;
            tbl_priv[pos]  = rq.priv_value;
            tbl_favor[pos] = rq.favor_flag;
            tbl_count++;
        end
        return rs;
    endfunction

    function automatic skt_req_t make_req(logic kind, logic signed [15:0] key,
                                          logic [15:0] pv, logic fv);
        skt_req_t rq;
        rq.req_type   = kind;
        rq.section_id = key;
        rq.priv_value = pv;
        rq.favor_flag = fv;
        return rq;
    endfunction

    // send one request, record its expected response, maybe idle afterwards
    task automatic send_request(input skt_req_t rq);
        req_data  <= rq;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        pending_rsp.push_back(table_access(rq));
        if (!quiet_run && $urandom_range(0, 99) < 13)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 24)) @(posedge clk);
        end
    endtask

    task automatic do_get(logic signed [15:0] key);
        send_request(make_req(REQ_GET, key, 16'($urandom), 1'($urandom)));
    endtask

    task automatic do_set(logic signed [15:0] key, logic [15:0] pv, logic fv);
        send_request(make_req(REQ_SET, key, pv, fv));
    endtask

    // stop sending and wait until every response is back
    task automatic drain_requests();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_rsp.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    // none_priv write, only with the block idle
    task automatic write_miss_mask(logic [15:0] value);
        drain_requests();
        cfg_wr_data <= value;
        cfg_wr_en   <= 1'b1;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        miss_mask    = value;
        @(posedge clk);
    endtask

    // response stall
    always @(posedge clk)
        rsp_stall <= !quiet_run && ($urandom_range(0, 99) < 13);

    // response check
    always @(posedge clk)
    begin : rsp_check
        skt_rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_rsp.size() == 0)
            begin
                $error("response with no request waiting: %p", rsp_data);
                err_count++;
            end
            else
            begin
                want = pending_rsp.pop_front();
                if (rsp_data.priv_out !== want.priv_out)
                begin
                    $error("priv_out: expected %h, got %h", want.priv_out, rsp_data.priv_out);
                    err_count++;
                end
                if (rsp_data.favor_out !== want.favor_out)
                begin
                    $error("favor_out: expected %b, got %b", want.favor_out,
                           rsp_data.favor_out);
                    err_count++;
                end
                if (rsp_data.status !== want.status)
                begin
                    $error("status: expected %b, got %b", want.status, rsp_data.status);
                    err_count++;
                end
            end
        end
    end

    // gets on an empty table fall back to the global mask or none_priv
    task automatic test_empty_table();
        do_get(16'sd0);
        do_get(16'sd1);
        do_get(-16'sd1);
        do_get(16'sh7FFF);
        do_get(16'sh8000);
    endtask

    // key extremes, key 0, insert in the middle, in-place update
    task automatic test_directed_sets();
        do_set(16'sd0, 16'hFFFF, 1'b1);
        do_get(16'sd5);
        do_get(-16'sd5);
        do_set(16'sh8000, 16'h0001, 1'b1);
        do_set(16'sh7FFF, 16'h8000, 1'b0);
        do_set(16'sd1, 16'hFFFF, 1'b1);
        do_set(-16'sd1, 16'h0000, 1'b1);
        do_set(16'sd100, 16'hA5A5, 1'b0);
        do_get(16'sh8000);
        do_get(16'sh7FFF);
        do_get(16'sd1);
        do_get(-16'sd1);
        do_get(16'sd100);
        do_get(16'sd0);
        do_get(16'sd2);
        do_set(16'sd1, 16'h1234, 1'b0);
        do_get(16'sd1);
        do_set(16'sd0, 16'h5A5A, 1'b0);
        do_get(16'sd0);
        do_get(16'sd99);
    endtask

    // negative misses, a positive miss and a hit under several none_priv settings
    task automatic test_miss_mask();
        logic [15:0] setting [3];
        setting[0] = 16'hFFFF;
        setting[1] = 16'h0000;
        setting[2] = 16'($urandom);
        foreach (setting[s])
        begin
            write_miss_mask(setting[s]);
            do_get(-16'sd2);
            do_get(16'sh8001);
            do_get(-16'sd1);
            do_get(16'sd3);
        end
    endtask

    // random gets and sets, mostly on a small pool of keys
    task automatic test_random_mix(int n);
        logic signed [15:0] pool [48];
        logic signed [15:0] key;
        pool[0] = 16'sd0;
        pool[1] = 16'sh8000;
        pool[2] = 16'sh7FFF;
        pool[3] = -16'sd1;
        pool[4] = 16'sd1;
        for (int i = 5; i < 48; i++)
            pool[i] = 16'($urandom);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 99) < 70)
                key = pool[$urandom_range(0, 47)];
            else
                key = 16'($urandom);
            send_request(make_req(1'($urandom), key, 16'($urandom), 1'($urandom)));
        end
    endtask

    // fill to capacity back to back, then inserts into a full table
    task automatic test_fill_table();
        logic signed [15:0] key;
        int                 guard;
        drain_requests();
        quiet_run = 1'b1;
        guard     = 0;
        while (tbl_count < TABLE_DEPTH && guard < 2000)
        begin
            do
                key = 16'($urandom);
            while (key == 0 || key_present(key));
            do_set(key, 16'($urandom), 1'($urandom));
            guard++;
        end
        // new keys are dropped once full
        for (int i = 0; i < 6; i++)
        begin
            do
                key = 16'($urandom);
            while (key == 0 || key_present(key));
            do_set(key, 16'($urandom), 1'($urandom));
            do_get(key);
        end
        // existing keys and the global mask still take writes
        do_set(tbl_key[0], 16'hFFFF, 1'b1);
        do_get(tbl_key[0]);
        do_set(tbl_key[TABLE_DEPTH-1], 16'h0000, 1'b0);
        do_get(tbl_key[TABLE_DEPTH-1]);
        do_set(16'sd0, 16'h0F0F, 1'b1);
        do_get(16'sd0);
        drain_requests();
        quiet_run = 1'b0;
    endtask

    // random traffic against a full table
    task automatic test_full_random(int n);
        logic signed [15:0] key;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 99) < 60)
                key = tbl_key[$urandom_range(0, tbl_count - 1)];
            else
                key = 16'($urandom);
            send_request(make_req(1'($urandom), key, 16'($urandom), 1'($urandom)));
        end
    endtask

    // test sequence
    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_table();
        test_directed_sets();
        test_miss_mask();
        test_random_mix(500);
        write_miss_mask(16'($urandom));
        test_random_mix(400);
        test_fill_table();
        write_miss_mask(16'hFFFF);
        test_full_random(700);
        drain_requests();
        repeat (30) @(posedge clk);
        if (err_count == 0)
            $display("tb_sorted_key_priv_table_unit: done, clean");
        else
            $display("tb_sorted_key_priv_table_unit: done, errors");
        $finish;
    end

    // run limit
    initial
    begin
        #2_000_000;
        $display("tb_sorted_key_priv_table_unit: done, errors");
        $finish;
    end

endmodule
